// File: hdl/polynomial_horner_evaluator_assert.svh
// assertion macros for the polynomial horner evaluator
// used by the top level only, no other dependencies
`ifndef POLYNOMIAL_HORNER_EVALUATOR_ASSERT_SVH
`define POLYNOMIAL_HORNER_EVALUATOR_ASSERT_SVH

// same-cycle implication
`define PHE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PHE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/phe_pkg.sv
// shared types and constants for the polynomial horner evaluator
// no dependencies
`default_nettype none

package phe_pkg;

  localparam int COEF_W         = 32;
  localparam int FRAC_BITS      = 16;
  localparam int PROD_W         = 2 * COEF_W;
  localparam int SUM_W          = PROD_W - FRAC_BITS + 1;
  localparam int PAIR_W         = 2 * COEF_W;
  localparam int NUM_PAIRS      = 5;
  localparam int DEG_W          = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int MAX_DEGREE_DEF = 9;

  localparam logic [CFG_IDX_W-1:0] REG_DEGREE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_4 = 3'd5;

  typedef struct packed {
    logic signed [COEF_W-1:0] r;
    logic signed [COEF_W-1:0] x;
    logic                     sat;
  } phe_item_t;

  typedef struct packed {
    logic mul_vld;
    logic add_vld;
  } phe_stage_t;

endpackage

`default_nettype wire

// File: hdl/phe_step.sv
// one horner step: registered multiply, then shift, add and saturate
// depends on phe_pkg
`default_nettype none

module phe_step import phe_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic signed [COEF_W-1:0] coef_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire phe_item_t                in_item_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output phe_item_t                     out_item_o,
  output phe_stage_t                    stat_o
);

  logic                     mul_vld_q;
  logic signed [PROD_W-1:0] mul_prod_q, mul_prod_d;
  logic signed [COEF_W-1:0] mul_x_q;
  logic                     mul_sat_q;
  logic                     add_vld_q;
  phe_item_t                add_item_q, add_item_d;
  logic                     mul_rdy, add_rdy;
  logic signed [COEF_W-1:0] r_s, x_s;
  logic [SUM_W-2:0]         shifted;
  logic [SUM_W-1:0]         sum;
  logic [SUM_W-COEF_W:0]    sum_top;
  logic                     ovf;

  assign add_rdy    = !add_vld_q || out_ready_i;
  assign mul_rdy    = !mul_vld_q || add_rdy;
  assign in_ready_o = mul_rdy;

  assign r_s        = in_item_i.r;
  assign x_s        = in_item_i.x;
  assign mul_prod_d = r_s * x_s;

  // arithmetic shift right by the fraction bits, then add the coefficient
  assign shifted = mul_prod_q[PROD_W-1:FRAC_BITS];
  assign sum     = {shifted[SUM_W-2], shifted}
                 + {{(SUM_W-COEF_W){coef_i[COEF_W-1]}}, coef_i};
  assign sum_top = sum[SUM_W-1:COEF_W-1];
  assign ovf     = !((&sum_top) || !(|sum_top));

  always_comb begin
    add_item_d.x   = mul_x_q;
    add_item_d.sat = mul_sat_q || ovf;
    if (!ovf) begin
      add_item_d.r = sum[COEF_W-1:0];
    end else if (sum[SUM_W-1]) begin
      add_item_d.r = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      add_item_d.r = {1'b0, {(COEF_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      add_vld_q <= 1'b0;
    end else begin
      if (mul_rdy) begin
        mul_vld_q <= in_valid_i;
      end
      if (add_rdy) begin
        add_vld_q <= mul_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_rdy && in_valid_i) begin
      mul_prod_q <= mul_prod_d;
      mul_x_q    <= in_item_i.x;
      mul_sat_q  <= in_item_i.sat;
    end
    if (add_rdy && mul_vld_q) begin
      add_item_q <= add_item_d;
    end
  end

  assign out_valid_o    = add_vld_q;
  assign out_item_o     = add_item_q;
  assign stat_o.mul_vld = mul_vld_q;
  assign stat_o.add_vld = add_vld_q;

endmodule

`default_nettype wire

// File: hdl/polynomial_horner_evaluator.sv
// polynomial evaluator by horner's rule, signed q16.16, saturating
// depends on phe_pkg, phe_step and polynomial_horner_evaluator_assert.svh
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[31:0] point
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata[31:0] value, tuser[0] saturated
//  cfg       in   cfg_we_i                     cfg_idx_i register, cfg_data_i value
//
// one item per cycle while m_axis_tready holds; one multiply stage and one
// add/saturate stage for each of the MAX_DEGREE horner steps
// every stage has its own valid bit; a stalled output fills empty stages first
// reset clears all valid bits and the configuration registers
`default_nettype none

module polynomial_horner_evaluator import phe_pkg::*; #(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [COEF_W-1:0]    s_axis_tdata,   // [31:0] point
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [COEF_W-1:0]         m_axis_tdata,   // [31:0] value
  output logic                      m_axis_tuser,   // [0] saturated
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [PAIR_W-1:0]    cfg_data_i
);

`include "polynomial_horner_evaluator_assert.svh"

  logic [DEG_W-1:0]         degree_q;
  logic [PAIR_W-1:0]        coef_pair_q [NUM_PAIRS];
  logic [CFG_IDX_W-1:0]     pair_sel;
  logic [DEG_W-1:0]         deg_eff;
  logic signed [COEF_W-1:0] eff_coef [MAX_DEGREE+1];
  phe_item_t                item_w  [MAX_DEGREE+1];
  logic                     valid_w [MAX_DEGREE+1];
  logic                     ready_w [MAX_DEGREE+1];
  phe_stage_t               stat_w  [MAX_DEGREE];
  logic [2*MAX_DEGREE-1:0]  occ;

  // configuration registers
  assign pair_sel = cfg_idx_i - REG_COEF_PAIR_0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
      for (int i = 0; i < NUM_PAIRS; i++) begin
        coef_pair_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        REG_DEGREE: begin
          degree_q <= cfg_data_i[DEG_W-1:0];
        end
        [REG_COEF_PAIR_0:REG_COEF_PAIR_4]: begin
          coef_pair_q[pair_sel] <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign deg_eff = (degree_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_q;

  // coefficients above the degree count as zero
  for (genvar k = 0; k <= MAX_DEGREE; k++) begin : g_coef
    localparam int PairIdx = k / 2;
    localparam int HalfLo  = (k % 2) * COEF_W;
    assign eff_coef[k] = (DEG_W'(k) <= deg_eff) ?
                         coef_pair_q[PairIdx][HalfLo +: COEF_W] : '0;
  end

  assign item_w[0].r    = eff_coef[MAX_DEGREE];
  assign item_w[0].x    = s_axis_tdata;
  assign item_w[0].sat  = 1'b0;
  assign valid_w[0]     = s_axis_tvalid;
  assign s_axis_tready  = ready_w[0];

  for (genvar g = 0; g < MAX_DEGREE; g++) begin : g_step
    phe_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .coef_i      (eff_coef[MAX_DEGREE-1-g]),
      .in_valid_i  (valid_w[g]),
      .in_ready_o  (ready_w[g]),
      .in_item_i   (item_w[g]),
      .out_valid_o (valid_w[g+1]),
      .out_ready_i (ready_w[g+1]),
      .out_item_o  (item_w[g+1]),
      .stat_o      (stat_w[g])
    );
    assign occ[2*g]   = stat_w[g].mul_vld;
    assign occ[2*g+1] = stat_w[g].add_vld;
  end

  assign ready_w[MAX_DEGREE] = m_axis_tready;
  assign m_axis_tvalid       = valid_w[MAX_DEGREE];
  assign m_axis_tdata        = item_w[MAX_DEGREE].r;
  assign m_axis_tuser        = item_w[MAX_DEGREE].sat;

  // checks
  `PHE_ASSERT_IMP(a_empty_ready, clk_i, rst_ni, $countones(occ) == 0, s_axis_tready,
                  "empty pipeline refuses an item")
  `PHE_ASSERT_NXT(a_accept_enters, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
                  stat_w[0].mul_vld, "accepted item did not enter the first stage")
  `PHE_ASSERT_NXT(a_last_moves, clk_i, rst_ni,
                  stat_w[MAX_DEGREE-1].mul_vld && !stat_w[MAX_DEGREE-1].add_vld,
                  stat_w[MAX_DEGREE-1].add_vld, "last multiply stage did not advance")

endmodule

`default_nettype wire

// File: test/tb_top.sv
// testbench for polynomial_horner_evaluator: streams evaluation points under random
// configurations and backpressure, checks each value and flag against a horner predictor
// depends on phe_pkg and the polynomial_horner_evaluator rtl
`default_nettype none

module tb_top;
  import phe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [COEF_W-1:0]    Q_MAX        = 32'h7fff_ffff;
  localparam logic [COEF_W-1:0]    Q_MIN        = 32'h8000_0000;
  localparam logic [COEF_W-1:0]    Q_ONE        = 32'h0001_0000;
  localparam logic [COEF_W-1:0]    Q_NEG_ONE    = 32'hffff_0000;
  localparam logic [COEF_W-1:0]    Q_NEG_ULP    = 32'hffff_ffff;
  localparam longint               SAT_HI       = 64'sd2147483647;
  localparam longint               SAT_LO       = -64'sd2147483648;
  localparam int                   DRAIN_CYCLES = 2 * MAX_DEGREE_DEF + 4;

  typedef struct {
    logic [COEF_W-1:0] value;
    logic              saturated;
  } eval_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [COEF_W-1:0]    s_axis_tdata = '0;    // [31:0] point
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [COEF_W-1:0]    m_axis_tdata;         // [31:0] value
  logic                 m_axis_tuser;         // [0] saturated
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [PAIR_W-1:0]    cfg_data_i = '0;

  logic [DEG_W-1:0]     poly_degree;
  logic [PAIR_W-1:0]    coef_pairs [NUM_PAIRS];
  eval_result_t         pending_evals [$];
  int                   mismatch_count = 0;
  bit                   no_idle = 1'b0;

  polynomial_horner_evaluator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic longint coef_value(input int unsigned k);
    logic [PAIR_W-1:0] pr;
    pr = coef_pairs[k / 2];
    if (k % 2) begin
      return longint'($signed(pr[PAIR_W-1:COEF_W]));
    end
    return longint'($signed(pr[COEF_W-1:0]));
  endfunction

  function automatic eval_result_t horner_predict(input logic [COEF_W-1:0] x_bits);
    eval_result_t res;
    int unsigned  d;
    int unsigned  k;
    longint       acc;
    longint       t;
    longint       xs;
    d = (poly_degree > MAX_DEGREE_DEF) ? MAX_DEGREE_DEF : poly_degree;
    xs = longint'($signed(x_bits));
    acc = coef_value(d);
    res.saturated = 1'b0;
    for (k = d; k > 0; k--) begin
      t = ((acc * xs) >>> FRAC_BITS) + coef_value(k - 1);
      if (t > SAT_HI) begin
        t = SAT_HI;
        res.saturated = 1'b1;
      end else if (t < SAT_LO) begin
        t = SAT_LO;
        res.saturated = 1'b1;
      end
      acc = t;
    end
    res.value = acc[COEF_W-1:0];
    return res;
  endfunction

  // random q16.16 with a random magnitude, extremes now and then
  function automatic logic [COEF_W-1:0] rand_q16();
    logic signed [COEF_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 19))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return Q_ONE;
      3: return Q_NEG_ONE;
      default: return v >>> $urandom_range(0, 31);
    endcase
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 19);
  end

  always @(posedge clk_i) begin
    eval_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_evals.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch: unexpected result value=%h sat=%b", m_axis_tdata, m_axis_tuser);
        end
      end else begin
        exp_res = pending_evals.pop_front();
        if (m_axis_tdata !== exp_res.value || m_axis_tuser !== exp_res.saturated) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected value=%h sat=%b, got value=%h sat=%b",
                     exp_res.value, exp_res.saturated, m_axis_tdata, m_axis_tuser);
          end
        end
      end
    end
  end

  task automatic send_point(input logic [COEF_W-1:0] x);
    while (!no_idle && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_evals.push_back(horner_predict(x));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_evals.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [PAIR_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == REG_DEGREE) begin
      poly_degree = data[DEG_W-1:0];
    end else if (idx >= REG_COEF_PAIR_0 && idx <= REG_COEF_PAIR_4) begin
      coef_pairs[idx - REG_COEF_PAIR_0] = data;
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_all_coefs(input logic [COEF_W-1:0] c);
    int i;
    for (i = 0; i < NUM_PAIRS; i++) begin
      cfg_write(CFG_IDX_W'(REG_COEF_PAIR_0 + i), {c, c});
    end
  endtask

  task automatic test_reset_defaults();
    send_point(Q_MAX);
    send_point(Q_MIN);
    wait_idle();
  endtask

  task automatic test_degree_zero();
    cfg_write(REG_DEGREE, {{(PAIR_W-DEG_W){1'b1}}, 4'd0});
    cfg_write(REG_COEF_PAIR_0, {Q_MAX, Q_MIN});
    send_point(Q_MAX);
    send_point(Q_NEG_ULP);
    send_point('0);
    wait_idle();
  endtask

  task automatic test_full_scale();
    cfg_write(REG_DEGREE, PAIR_W'(MAX_DEGREE_DEF));
    set_all_coefs(Q_MAX);
    send_point(Q_MAX);
    send_point(Q_MIN);
    send_point('0);
    send_point(Q_NEG_ULP);
    send_point(Q_ONE);
    send_point(Q_NEG_ONE);
    wait_idle();
    set_all_coefs(Q_MIN);
    send_point(Q_MAX);
    send_point(Q_NEG_ONE);
    wait_idle();
  endtask

  // degree above the maximum acts as the maximum; spare indexes are ignored
  task automatic test_degree_clamp();
    int i;
    for (i = 0; i < NUM_PAIRS; i++) begin
      cfg_write(CFG_IDX_W'(REG_COEF_PAIR_0 + i), {rand_q16() >>> 4, rand_q16() >>> 4});
    end
    cfg_write(REG_DEGREE, PAIR_W'(15));
    send_point(Q_ONE);
    send_point(32'h0000_8000);
    send_point(32'hfffe_c000);
    wait_idle();
    cfg_write(REG_DEGREE, PAIR_W'(10));
    send_point(32'h0000_8000);
    wait_idle();
    cfg_write(REG_SPARE_LO, {$urandom, $urandom});
    cfg_write(REG_SPARE_HI, {$urandom, $urandom});
    send_point(Q_ONE);
    send_point(Q_NEG_ONE);
    wait_idle();
  endtask

  task automatic test_unused_coefs();
    cfg_write(REG_DEGREE, PAIR_W'(1));
    set_all_coefs(Q_MAX);
    cfg_write(REG_COEF_PAIR_0, {Q_NEG_ONE, Q_ONE});
    send_point(32'h0002_0000);
    send_point(Q_MIN);
    wait_idle();
  endtask

  task automatic test_random_stream(input int phases, input int items_per_phase);
    int               p;
    int               i;
    logic [PAIR_W-1:0] data;
    for (p = 0; p < phases; p++) begin
      data = {$urandom, $urandom};
      if (p == 0) begin
        data[DEG_W-1:0] = DEG_W'(MAX_DEGREE_DEF);
      end else if (p == 1) begin
        data[DEG_W-1:0] = '0;
      end else if ($urandom_range(0, 99) < 80) begin
        data[DEG_W-1:0] = DEG_W'($urandom_range(0, MAX_DEGREE_DEF));
      end else begin
        data[DEG_W-1:0] = DEG_W'($urandom_range(MAX_DEGREE_DEF + 1, 15));
      end
      cfg_write(REG_DEGREE, data);
      for (i = 0; i < NUM_PAIRS; i++) begin
        cfg_write(CFG_IDX_W'(REG_COEF_PAIR_0 + i), {rand_q16(), rand_q16()});
      end
      if ($urandom_range(0, 3) == 0) begin
        cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
      end
      no_idle = (p == 6 || p == 7);
      for (i = 0; i < items_per_phase; i++) begin
        send_point(rand_q16());
      end
      wait_idle();
      no_idle = 1'b0;
    end
  endtask

  initial begin
    int i;
    poly_degree = '0;
    for (i = 0; i < NUM_PAIRS; i++) begin
      coef_pairs[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_degree_zero();
    test_full_scale();
    test_degree_clamp();
    test_unused_coefs();
    test_random_stream(13, 150);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_evals.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: polynomial_horner_evaluator.f
+incdir+hdl
hdl/phe_pkg.sv
hdl/phe_step.sv
hdl/polynomial_horner_evaluator.sv
test/tb_top.sv
